FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a must imply b in the same cycle
`define ASSERT_IMPLIES(label, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed: same-cycle implication");

// a must imply b in the next cycle
`define ASSERT_NEXT(label, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed: next-cycle implication");

`endif

FILE: sv/ftsm_pkg.sv
// ----------------------------------------------------------------------------
// ftsm_pkg
// Types and constants of the fan tachometer speed monitor.
// ----------------------------------------------------------------------------
package ftsm_pkg;

  localparam int unsigned CAP_W   = 32;
  localparam int unsigned SPEED_W = 32;
  localparam int unsigned CNT_W   = 8;
  localparam int unsigned MIN_W   = 28;
  localparam int unsigned CFG_W   = 32;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned STEP_W  = $clog2(SPEED_W);

  localparam logic [MIN_W-1:0]   MIN_START   = 28'hFFFFFFF;
  localparam logic [CFG_W-1:0]   NUM_RESET   = 32'd22500000;
  localparam logic [CNT_W-1:0]   THR_RESET   = 8'd10;
  localparam logic [CNT_W-1:0]   CNT_MAX     = 8'd255;
  localparam logic [STEP_W-1:0]  STEP_LAST   = STEP_W'(SPEED_W - 1);

  localparam logic [CFG_IDX_W-1:0] REG_SPEED_NUM = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_THR  = 1'b1;

  typedef struct packed {
    logic update_min;
    logic load_empty;
    logic start_div;
    logic div_step;
    logic load_speed;
  } cmd_t;

  typedef struct packed {
    logic step_last;
  } sts_t;

endpackage

FILE: sv/ftsm_ctrl.sv
// ----------------------------------------------------------------------------
// ftsm_ctrl
// Controller: input handshake, divide sequencing and output valid.
// ----------------------------------------------------------------------------
module ftsm_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic           in_operation,
  input  logic           in_last_pair,
  output logic           out_valid,
  input  logic           out_stall,
  output ftsm_pkg::cmd_t cmd,
  input  ftsm_pkg::sts_t sts
);

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_FIN} state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   in_take;

  assign in_stall = (state_r != S_IDLE) | (out_valid_r & out_stall);
  assign in_take  = in_valid & ~in_stall;

  always_comb begin
    cmd            = '0;
    cmd.update_min = in_take & ~in_operation & ~in_last_pair;
    cmd.load_empty = in_take & in_operation;
    cmd.start_div  = in_take & ~in_operation & in_last_pair;
    cmd.div_step   = (state_r == S_DIV);
    cmd.load_speed = (state_r == S_FIN);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cmd.start_div) state_nxt = S_DIV;
      end
      S_DIV: begin
        if (sts.step_last) state_nxt = S_FIN;
      end
      S_FIN: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    out_valid_nxt = cmd.load_empty | cmd.load_speed | (out_valid_r & out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

FILE: sv/ftsm_datapath.sv
// ----------------------------------------------------------------------------
// ftsm_datapath
// Configuration, running minimum, error count, radix-2 divider and output
// register.
// ----------------------------------------------------------------------------
module ftsm_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [ftsm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ftsm_pkg::CFG_W-1:0]          cfg_wdata,
  input  logic [ftsm_pkg::CAP_W-1:0]          in_first_capture,
  input  logic [ftsm_pkg::CAP_W-1:0]          in_second_capture,
  output logic [ftsm_pkg::SPEED_W-1:0]        out_fan_speed,
  output logic [ftsm_pkg::CNT_W-1:0]          out_error_count,
  output logic                                out_fan_stopped,
  input  ftsm_pkg::cmd_t                      cmd,
  output ftsm_pkg::sts_t                      sts
);

  logic [ftsm_pkg::CFG_W-1:0]   num_r, num_nxt;
  logic [ftsm_pkg::CNT_W-1:0]   thr_r, thr_nxt;
  logic [ftsm_pkg::MIN_W-1:0]   min_r, min_nxt;
  logic [ftsm_pkg::CNT_W-1:0]   err_r, err_nxt;
  logic [ftsm_pkg::STEP_W-1:0]  cnt_r, cnt_nxt;
  logic [ftsm_pkg::MIN_W-1:0]   rem_r, rem_nxt;
  logic [ftsm_pkg::SPEED_W-1:0] quo_r, quo_nxt;
  logic [ftsm_pkg::MIN_W-1:0]   dvs_r, dvs_nxt;
  logic [ftsm_pkg::SPEED_W-1:0] speed_r, speed_nxt;
  logic [ftsm_pkg::CNT_W-1:0]   oerr_r, oerr_nxt;
  logic                         ostop_r, ostop_nxt;

  logic [ftsm_pkg::CAP_W-1:0]   period;
  logic [ftsm_pkg::MIN_W-1:0]   pair_min;
  logic [ftsm_pkg::CNT_W-1:0]   err_inc;
  logic [ftsm_pkg::MIN_W:0]     shifted;
  logic [ftsm_pkg::MIN_W:0]     diff;
  logic                         ge;

  always_comb begin
    period   = in_second_capture - in_first_capture;
    pair_min = min_r;
    if ((period != '0) && (period < {{(ftsm_pkg::CAP_W - ftsm_pkg::MIN_W){1'b0}}, min_r}))
      pair_min = period[ftsm_pkg::MIN_W-1:0];

    err_inc = (err_r == ftsm_pkg::CNT_MAX) ? err_r : err_r + 1'b1;

    shifted = {rem_r, quo_r[ftsm_pkg::SPEED_W-1]};
    diff    = shifted - {1'b0, dvs_r};
    ge      = (shifted >= {1'b0, dvs_r});

    num_nxt = num_r;
    thr_nxt = thr_r;
    if (cfg_we) begin
      case (cfg_index)
        ftsm_pkg::REG_SPEED_NUM: num_nxt = cfg_wdata;
        ftsm_pkg::REG_STOP_THR:  thr_nxt = cfg_wdata[ftsm_pkg::CNT_W-1:0];
        default: begin
          num_nxt = num_r;
        end
      endcase
    end

    min_nxt   = min_r;
    err_nxt   = err_r;
    cnt_nxt   = cnt_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    dvs_nxt   = dvs_r;
    speed_nxt = speed_r;
    oerr_nxt  = oerr_r;
    ostop_nxt = ostop_r;

    if (cmd.update_min) min_nxt = pair_min;

    if (cmd.load_empty) begin
      min_nxt   = ftsm_pkg::MIN_START;
      err_nxt   = err_inc;
      speed_nxt = '0;
      oerr_nxt  = err_inc;
      ostop_nxt = (err_inc > thr_r);
    end

    if (cmd.start_div) begin
      min_nxt = ftsm_pkg::MIN_START;
      err_nxt = '0;
      cnt_nxt = '0;
      rem_nxt = '0;
      quo_nxt = num_r;
      dvs_nxt = pair_min;
    end

    if (cmd.div_step) begin
      cnt_nxt = cnt_r + 1'b1;
      rem_nxt = ge ? diff[ftsm_pkg::MIN_W-1:0] : shifted[ftsm_pkg::MIN_W-1:0];
      quo_nxt = {quo_r[ftsm_pkg::SPEED_W-2:0], ge};
    end

    if (cmd.load_speed) begin
      speed_nxt = quo_r;
      oerr_nxt  = err_r;
      ostop_nxt = (err_r > thr_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_r <= ftsm_pkg::NUM_RESET;
      thr_r <= ftsm_pkg::THR_RESET;
      min_r <= ftsm_pkg::MIN_START;
      err_r <= '0;
      cnt_r <= '0;
    end else begin
      num_r <= num_nxt;
      thr_r <= thr_nxt;
      min_r <= min_nxt;
      err_r <= err_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r   <= rem_nxt;
    quo_r   <= quo_nxt;
    dvs_r   <= dvs_nxt;
    speed_r <= speed_nxt;
    oerr_r  <= oerr_nxt;
    ostop_r <= ostop_nxt;
  end

  assign sts.step_last   = (cnt_r == ftsm_pkg::STEP_LAST);
  assign out_fan_speed   = speed_r;
  assign out_error_count = oerr_r;
  assign out_fan_stopped = ostop_r;

endmodule

FILE: sv/fan_tach_speed_monitor.sv
// ----------------------------------------------------------------------------
// fan_tach_speed_monitor
// Keeps the smallest nonzero capture period of a burst and divides the speed
// numerator by it on the last pair; counts empty reads and flags a stop.
//
//   channel  handshake            payload
//   in       in_valid / in_stall  operation, first/second capture, last_pair
//   out      out_valid / out_stall fan_speed, error_count, fan_stopped
//   cfg      cfg_we               cfg_index, cfg_wdata
//
// A non-final pair or an empty read needs no divide.
// A final pair is accepted, runs 32 steps of the radix-2 divider, then loads the result.
// Reset is synchronous; it restores register defaults, sets the minimum to its
// start value and clears the error count.
// Input is stalled while dividing and loading, and while a result waits under out_stall.
// ----------------------------------------------------------------------------
module fan_tach_speed_monitor (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [ftsm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ftsm_pkg::CFG_W-1:0]      cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_operation,
  input  logic [ftsm_pkg::CAP_W-1:0]      in_first_capture,
  input  logic [ftsm_pkg::CAP_W-1:0]      in_second_capture,
  input  logic                            in_last_pair,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [ftsm_pkg::SPEED_W-1:0]    out_fan_speed,
  output logic [ftsm_pkg::CNT_W-1:0]      out_error_count,
  output logic                            out_fan_stopped
);

  ftsm_pkg::cmd_t cmd;
  ftsm_pkg::sts_t sts;

  ftsm_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .in_last_pair (in_last_pair),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .cmd          (cmd),
    .sts          (sts)
  );

  ftsm_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_first_capture  (in_first_capture),
    .in_second_capture (in_second_capture),
    .out_fan_speed     (out_fan_speed),
    .out_error_count   (out_error_count),
    .out_fan_stopped   (out_fan_stopped),
    .cmd               (cmd),
    .sts               (sts)
  );

endmodule

FILE: sv/ftsm_chk.sv
// ----------------------------------------------------------------------------
// ftsm_chk
// Port-level checks of the fan tachometer speed monitor, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ftsm_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic                            in_operation,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [ftsm_pkg::SPEED_W-1:0]    out_fan_speed,
  input logic [ftsm_pkg::CNT_W-1:0]      out_error_count,
  input logic                            out_fan_stopped
);

  `ASSERT_IMPLIES(a_hold_input, out_valid && out_stall, in_stall)
  `ASSERT_NEXT(a_empty_result, in_valid && !in_stall && in_operation, out_valid)
  `ASSERT_IMPLIES(a_stop_count, out_valid && out_fan_stopped, out_error_count != '0)
  `ASSERT_IMPLIES(a_speed_clears, out_valid && (out_fan_speed != '0), out_error_count == '0)
  `ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_fan_speed))

endmodule

bind fan_tach_speed_monitor ftsm_chk u_ftsm_chk (.*);
